// File: sv/assert_macros.svh
// Assertion shorthands shared by the RTL; clocked on clk, off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HSPI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HSPI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/hspi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hspi_pkg;

	localparam int CAP_W      = 16;
	localparam int PERIOD_W   = CAP_W + 1;
	localparam int SPEED_W    = 24;
	localparam int ERR_W      = 25;
	localparam int GAIN_W     = 16;
	localparam int WARM_W     = 8;
	localparam int CNT_W      = 8;
	localparam int SUM_W      = 48;
	localparam int MCAND_W    = 64;
	localparam int ACC_W      = 65;
	localparam int FRAC_W     = 16;
	localparam int DUTY_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int STEP_W     = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REF_SPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR = 3'd4;

	// reset values
	localparam logic [CAP_W-1:0]   RST_REF_SPEED = 16'd12190;
	localparam logic [GAIN_W-1:0]  RST_KP_GAIN   = 16'd3277;
	localparam logic [GAIN_W-1:0]  RST_KI_GAIN   = 16'd328;
	localparam logic [WARM_W-1:0]  RST_WARMUP    = 8'd10;
	localparam logic [SPEED_W-1:0] RST_NUMERATOR = 24'd424440;

	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	localparam logic [STEP_W-1:0] DIV_LAST  = 5'd23;
	localparam logic [STEP_W-1:0] MUL_SWAP  = 5'd15;
	localparam logic [STEP_W-1:0] MUL_LAST  = 5'd31;

	typedef logic [STEP_W-1:0] step_t;

endpackage

`default_nettype wire

// File: sv/hall_speed_pi_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall  capture_value[15:0]
// out       out  out_valid / out_stall duty[7:0], speed[23:0], speed_error[24:0] (signed)
// cfg       in   cfg_write            cfg_index[2:0], cfg_data[23:0]
//
// One event runs from its transfer to a loaded result through the bit-serial
// restoring divider, the error and integrator update, the shift-add multiplier
// (16 kp bits, then 16 ki bits), and a final clamp and load. The next event
// can transfer in the cycle after the load. in_stall is high while an event
// is in work; a waiting result holds only the last step. arst_n clears the
// control state and loads register reset values.

module hall_speed_pi_controller_top
	import hspi_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input events
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [CAP_W-1:0]              capture_value,
	// results
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [DUTY_W-1:0]                  duty,
	output logic [SPEED_W-1:0]                 speed,
	output logic signed [ERR_W-1:0]            speed_error,
	// configuration
	input  wire logic                          cfg_write,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

	`include "assert_macros.svh"

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	// configuration registers
	logic [CAP_W-1:0]   ref_speed_q;
	logic [GAIN_W-1:0]  kp_gain_q;
	logic [GAIN_W-1:0]  ki_gain_q;
	logic [WARM_W-1:0]  warmup_q;
	logic [SPEED_W-1:0] numerator_q;

	// control
	logic [2:0]        state_q;
	step_t             step_q;
	logic [CNT_W-1:0]  event_count_q;
	logic              warmed_q;
	logic              out_valid_q;

	// controller state
	logic signed [ERR_W-1:0] last_error_q;
	logic [SUM_W-1:0]        error_sum_q;

	// divider
	logic [PERIOD_W-1:0] period_q;
	logic [CAP_W-1:0]    rem_q;
	logic [SPEED_W-1:0]  dq_q;     // numerator bits out, quotient bits in

	// multiplier
	logic [MCAND_W-1:0] mcand_q;
	logic [GAIN_W-1:0]  mult_q;
	logic [ACC_W-1:0]   acc_q;

	// output registers
	logic [DUTY_W-1:0]       duty_q;
	logic [SPEED_W-1:0]      speed_q;
	logic signed [ERR_W-1:0] speed_error_q;

	logic in_xfer;
	logic out_xfer;
	logic can_load;

	logic [PERIOD_W:0]       trial;
	logic                    qbit;
	logic [CAP_W-1:0]        rem_next;
	logic signed [ERR_W-1:0] err_new;
	logic                    warmed_new;
	logic [SUM_W:0]          sum_ext;
	logic [SUM_W-1:0]        sum_sat;
	logic [ACC_W-1:0]        acc_next;
	logic [DUTY_W-1:0]       duty_new;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_xfer  = out_valid_q && !out_stall;
	assign can_load  = !out_valid_q || !out_stall;

	assign duty        = duty_q;
	assign speed       = speed_q;
	assign speed_error = speed_error_q;

	// one restoring-division step: shift in next numerator bit, try subtract
	always_comb begin
		trial    = {1'b0, rem_q, dq_q[SPEED_W-1]} - {1'b0, period_q};
		qbit     = !trial[PERIOD_W];
		// on a failed subtract the partial remainder is below period, so its top bit is 0
		rem_next = qbit ? trial[CAP_W-1:0] : {rem_q[CAP_W-2:0], dq_q[SPEED_W-1]};
	end

	// error, warm-up and saturating integrator
	always_comb begin
		err_new    = $signed({{(ERR_W-CAP_W){1'b0}}, ref_speed_q})
		           - $signed({1'b0, dq_q});
		warmed_new = (event_count_q > warmup_q);
		sum_ext    = {error_sum_q[SUM_W-1], error_sum_q}
		           + {{(SUM_W+1-ERR_W){last_error_q[ERR_W-1]}}, last_error_q};
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_ext[SUM_W-1:0];
		end
	end

	// shift-add multiply step and drive clamp
	always_comb begin
		acc_next = mult_q[0] ? acc_q + {mcand_q[MCAND_W-1], mcand_q} : acc_q;
		// negative sum truncates to <= 0 -> 0; anything >= 256 in Q16 -> 255
		if (acc_q[ACC_W-1]) begin
			duty_new = '0;
		end else if (|acc_q[ACC_W-2:FRAC_W+DUTY_W]) begin
			duty_new = '1;
		end else begin
			duty_new = acc_q[FRAC_W+DUTY_W-1:FRAC_W];
		end
	end

	// configuration writes; unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_speed_q <= RST_REF_SPEED;
			kp_gain_q   <= RST_KP_GAIN;
			ki_gain_q   <= RST_KI_GAIN;
			warmup_q    <= RST_WARMUP;
			numerator_q <= RST_NUMERATOR;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_REF_SPEED: ref_speed_q <= cfg_data[CAP_W-1:0];
				REG_KP_GAIN:   kp_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_KI_GAIN:   ki_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_WARMUP:    warmup_q    <= cfg_data[WARM_W-1:0];
				REG_NUMERATOR: numerator_q <= cfg_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// control path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			event_count_q <= '0;
			warmed_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			last_error_q  <= ERR_W'(signed'({1'b0, RST_REF_SPEED}));
			error_sum_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_DIV;
						step_q  <= '0;
						if (event_count_q != '1) begin
							event_count_q <= event_count_q + 1'b1;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == DIV_LAST) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					warmed_q     <= warmed_new;
					last_error_q <= err_new;
					if (warmed_new) begin
						error_sum_q <= sum_sat;
					end
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == MUL_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (state_q == ST_DONE && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					period_q <= {1'b1, {CAP_W{1'b0}}} - {1'b0, capture_value};
					rem_q    <= '0;
					dq_q     <= numerator_q;
				end
			end
			ST_DIV: begin
				rem_q <= rem_next;
				dq_q  <= {dq_q[SPEED_W-2:0], qbit};
			end
			ST_UPD: begin
				acc_q   <= '0;
				mcand_q <= {{(MCAND_W-ERR_W){err_new[ERR_W-1]}}, err_new};
				mult_q  <= kp_gain_q;
			end
			ST_MUL: begin
				acc_q <= acc_next;
				if (step_q == MUL_SWAP) begin
					// proportional part done; integral part only after warm-up
					mcand_q <= {{(MCAND_W-SUM_W){error_sum_q[SUM_W-1]}}, error_sum_q};
					mult_q  <= warmed_q ? ki_gain_q : '0;
				end else begin
					mcand_q <= {mcand_q[MCAND_W-2:0], 1'b0};
					mult_q  <= {1'b0, mult_q[GAIN_W-1:1]};
				end
			end
			ST_DONE: begin
				if (can_load) begin
					duty_q        <= duty_new;
					speed_q       <= dq_q;
					speed_error_q <= last_error_q;
				end
			end
			default: begin
			end
		endcase
	end

	// partial remainder always stays below the divisor
	`HSPI_ASSERT_IMP(a_rem_below_period, state_q == ST_DIV, {1'b0, rem_q} < period_q,
		"divider remainder not below period")
	// a new result appears only after the multiplier has finished
	`HSPI_ASSERT_IMP(a_result_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE,
		"result loaded outside the done step")
	// event counter only ever climbs
	`HSPI_ASSERT_IMP(a_count_monotonic, 1'b1, event_count_q >= $past(event_count_q),
		"event counter went down")
	// an accepted event always starts the divider
	`HSPI_ASSERT_NXT(a_accept_starts_div, in_xfer, state_q == ST_DIV && step_q == '0,
		"accepted event did not start division")

endmodule

`default_nettype wire
